[hdl/ipv4rhc_pkg.sv]
package ipv4rhc_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned SumWidth = 17;

   localparam logic [CountWidth-1:0] CountSaturate = 16'hFFFF;
   localparam logic [5:0] MinHeaderBytes = 6'd20;
   localparam logic [CountWidth-1:0] MinPacketBytes = 16'd20;
   localparam logic [CountWidth-1:0] IcmpHeaderBytes = 16'd8;
   localparam logic [SumWidth-1:0] ChecksumGood = 17'h0FFFF;
   localparam logic [3:0] IpVersion4 = 4'd4;
   localparam logic [3:0] MulticastPrefix = 4'hE;
   localparam logic [31:0] LimitedBroadcast = 32'hFFFF_FFFF;
   localparam logic [31:0] LocalAddressReset = 32'h0000_0000;
   localparam logic [15:0] EchoTypeCode = 16'h0800;

   localparam logic [CountWidth-1:0] LengthHighIndex = 16'd2;
   localparam logic [CountWidth-1:0] LengthLowIndex = 16'd3;
   localparam logic [CountWidth-1:0] ProtocolIndex = 16'd9;
   localparam logic [CountWidth-1:0] SourceIndex = 16'd12;
   localparam logic [CountWidth-1:0] DestinationIndex = 16'd16;
   localparam logic [CountWidth-1:0] FixedHeaderEnd = 16'd20;

   localparam logic [7:0] ProtocolIcmp = 8'd1;
   localparam logic [7:0] ProtocolTcp = 8'd6;
   localparam logic [7:0] ProtocolUdp = 8'd17;

   typedef enum logic [2:0] {
      VERDICT_ACCEPT,
      VERDICT_SHORT,
      VERDICT_VERSION,
      VERDICT_HEADER_LENGTH,
      VERDICT_CHECKSUM,
      VERDICT_NOT_OURS,
      VERDICT_TOTAL_LENGTH
   } verdict_type;

   typedef enum logic [1:0] {
      CLASS_OTHER,
      CLASS_ICMP,
      CLASS_TCP,
      CLASS_UDP
   } protocol_class_type;

   typedef struct packed {
      logic [CountWidth-1:0] received_length;
      logic [7:0]            version_ihl;
      logic [SumWidth-1:0]   header_sum;
      logic [15:0]           total_length;
      logic [7:0]            protocol;
      logic [31:0]           source;
      logic [31:0]           destination;
      logic [15:0]           icmp_type_code;
   } packet_summary_type;

   typedef struct packed {
      verdict_type        verdict;
      protocol_class_type protocol_class;
      logic [31:0]        source_address;
      logic [5:0]         header_length;
      logic [15:0]        payload_length;
      logic               echo_request;
   } result_type;

   function automatic logic [5:0] header_bytes(input logic [7:0] version_ihl);
      header_bytes = {version_ihl[3:0], 2'b00};
   endfunction

endpackage

[hdl/ipv4rhc_if.sv]
interface ipv4rhc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipv4rhc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [1:0]  protocol_class;
   logic [31:0] source_address;
   logic [5:0]  header_length;
   logic [15:0] payload_length;
   logic        echo_request;

   modport source (output valid, output verdict, output protocol_class,
                   output source_address, output header_length,
                   output payload_length, output echo_request, input ready);
   modport sink (input valid, input verdict, input protocol_class,
                 input source_address, input header_length,
                 input payload_length, input echo_request, output ready);
endinterface

[hdl/ipv4_receive_header_check.sv]
// Checks received IPv4 packets presented one byte per beat in wire order, with
// last_byte set on the final beat, and gives one verdict beat per packet; other
// beats give no result. A byte beat can be taken every cycle: each beat passes one
// input register, and the header capture and checksum logic updates on the
// beat as it leaves that register; the sustained rate is one byte per cycle
// while verdicts are taken. A verdict is registered as its last byte leaves the
// input register. Input only stalls when a final byte meets a result register
// whose previous verdict has not been taken. Dropped packets carry only the
// drop reason, with all other result fields zero. csr_write_data sets the local
// address and should be written only while no packet is in flight.
module ipv4_receive_header_check (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [31:0]          csr_write_data,
   ipv4rhc_req_if.sink          req_beat,
   ipv4rhc_rsp_if.source        rsp_beat
);

   logic [31:0]                     local_address_ff;
   logic                            hold_valid_ff, hold_valid_in;
   logic [7:0]                      hold_byte_ff;
   logic                            hold_last_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   ipv4rhc_pkg::result_type         rsp_result_ff;

   logic                            rsp_open;
   logic                            hold_take;
   logic                            rsp_load;
   ipv4rhc_pkg::packet_summary_type summary;
   ipv4rhc_pkg::result_type         result;

   ipv4rhc_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .beat_take (hold_take),
      .data_byte (hold_byte_ff),
      .last_byte (hold_last_ff),
      .summary   (summary)
   );

   ipv4rhc_judge u_judge (
      .summary       (summary),
      .local_address (local_address_ff),
      .result        (result)
   );

   always_comb begin
      rsp_open       = !rsp_valid_ff || rsp_beat.ready;
      hold_take      = hold_valid_ff && (!hold_last_ff || rsp_open);
      rsp_load       = hold_take && hold_last_ff;
      req_beat.ready = !hold_valid_ff || hold_take;
      hold_valid_in  = req_beat.ready ? req_beat.valid : hold_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_beat.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= ipv4rhc_pkg::LocalAddressReset;
         hold_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            local_address_ff <= csr_write_data;
         end
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat.ready && req_beat.valid) begin
         hold_byte_ff <= req_beat.data_byte;
         hold_last_ff <= req_beat.last_byte;
      end
      if (rsp_load) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_beat.valid          = rsp_valid_ff;
   assign rsp_beat.verdict        = rsp_result_ff.verdict;
   assign rsp_beat.protocol_class = rsp_result_ff.protocol_class;
   assign rsp_beat.source_address = rsp_result_ff.source_address;
   assign rsp_beat.header_length  = rsp_result_ff.header_length;
   assign rsp_beat.payload_length = rsp_result_ff.payload_length;
   assign rsp_beat.echo_request   = rsp_result_ff.echo_request;

   // A dropped packet carries nothing but its drop reason.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_beat.valid && rsp_beat.verdict != ipv4rhc_pkg::VERDICT_ACCEPT) |->
      (rsp_beat.protocol_class == '0 && rsp_beat.source_address == '0 &&
       rsp_beat.header_length == '0 && rsp_beat.payload_length == '0 &&
       !rsp_beat.echo_request))
      else $error("dropped packet result has nonzero fields");

   // An echo request is always an accepted ICMP packet.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_beat.valid && rsp_beat.echo_request) |->
      (rsp_beat.verdict == ipv4rhc_pkg::VERDICT_ACCEPT &&
       rsp_beat.protocol_class == ipv4rhc_pkg::CLASS_ICMP))
      else $error("echo request flagged on a non-ICMP or dropped packet");

   // An accepted packet has at least the fixed header.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_beat.valid && rsp_beat.verdict == ipv4rhc_pkg::VERDICT_ACCEPT) |->
      (rsp_beat.header_length >= ipv4rhc_pkg::MinHeaderBytes))
      else $error("accepted packet with a header below the minimum");

   // A verdict is loaded only from a final byte, and the register then shows it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_beat.valid && !$past(hold_valid_ff && !hold_last_ff)))
      else $error("result loaded without a final byte");

endmodule

[hdl/ipv4rhc_capture.sv]
module ipv4rhc_capture (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            beat_take,
   input  logic [7:0]                      data_byte,
   input  logic                            last_byte,
   output ipv4rhc_pkg::packet_summary_type summary
);

   logic [ipv4rhc_pkg::CountWidth-1:0] count_ff, count_in;
   logic [ipv4rhc_pkg::SumWidth-1:0]   sum_ff, sum_in;
   logic [7:0]                         held_ff, held_in;
   logic [7:0]                         version_ihl_ff, version_ihl_in;
   logic [15:0]                        total_ff, total_in;
   logic [7:0]                         protocol_ff, protocol_in;
   logic [31:0]                        source_ff, source_in;
   logic [31:0]                        destination_ff, destination_in;
   logic [15:0]                        icmp_ff, icmp_in;

   logic                               indexed;
   logic [ipv4rhc_pkg::CountWidth-1:0] header_end;
   logic [ipv4rhc_pkg::SumWidth:0]     word_sum;
   logic [ipv4rhc_pkg::SumWidth-1:0]   folded_sum;

   always_comb begin
      count_in       = count_ff;
      sum_in         = sum_ff;
      held_in        = held_ff;
      version_ihl_in = version_ihl_ff;
      total_in       = total_ff;
      protocol_in    = protocol_ff;
      source_in      = source_ff;
      destination_in = destination_ff;
      icmp_in        = icmp_ff;

      indexed = (count_ff != ipv4rhc_pkg::CountSaturate);
      if (indexed && count_ff == '0) begin
         version_ihl_in = data_byte;
      end
      header_end = {10'd0, ipv4rhc_pkg::header_bytes(version_ihl_in)};

      // Ones-complement add of one big-endian header word with end-around carry.
      word_sum   = {1'b0, sum_ff} + {2'b00, held_ff, data_byte};
      folded_sum = {1'b0, word_sum[15:0]} + {15'd0, word_sum[17:16]};

      if (indexed) begin
         if (count_ff < header_end) begin
            if (!count_ff[0]) begin
               held_in = data_byte;
            end else begin
               sum_in = folded_sum;
            end
         end
         if (count_ff == ipv4rhc_pkg::LengthHighIndex) begin
            total_in[15:8] = data_byte;
         end
         if (count_ff == ipv4rhc_pkg::LengthLowIndex) begin
            total_in[7:0] = data_byte;
         end
         if (count_ff == ipv4rhc_pkg::ProtocolIndex) begin
            protocol_in = data_byte;
         end
         if (count_ff >= ipv4rhc_pkg::SourceIndex &&
             count_ff < ipv4rhc_pkg::DestinationIndex) begin
            source_in = {source_ff[23:0], data_byte};
         end
         if (count_ff >= ipv4rhc_pkg::DestinationIndex &&
             count_ff < ipv4rhc_pkg::FixedHeaderEnd) begin
            destination_in = {destination_ff[23:0], data_byte};
         end
         if (count_ff == header_end) begin
            icmp_in[15:8] = data_byte;
         end
         if (count_ff == header_end + 16'd1) begin
            icmp_in[7:0] = data_byte;
         end
         count_in = count_ff + 16'd1;
      end
   end

   always_comb begin
      summary.received_length = count_in;
      summary.version_ihl     = version_ihl_in;
      summary.header_sum      = sum_in;
      summary.total_length    = total_in;
      summary.protocol        = protocol_in;
      summary.source          = source_in;
      summary.destination     = destination_in;
      summary.icmp_type_code  = icmp_in;
   end

   // The final beat of a packet leaves the state clear for the next packet.
   always_ff @(posedge clock) begin
      if (reset || (beat_take && last_byte)) begin
         count_ff       <= '0;
         sum_ff         <= '0;
         held_ff        <= '0;
         version_ihl_ff <= '0;
         total_ff       <= '0;
         protocol_ff    <= '0;
         source_ff      <= '0;
         destination_ff <= '0;
         icmp_ff        <= '0;
      end else if (beat_take) begin
         count_ff       <= count_in;
         sum_ff         <= sum_in;
         held_ff        <= held_in;
         version_ihl_ff <= version_ihl_in;
         total_ff       <= total_in;
         protocol_ff    <= protocol_in;
         source_ff      <= source_in;
         destination_ff <= destination_in;
         icmp_ff        <= icmp_in;
      end
   end

endmodule

[hdl/ipv4rhc_judge.sv]
module ipv4rhc_judge (
   input  ipv4rhc_pkg::packet_summary_type summary,
   input  logic [31:0]                     local_address,
   output ipv4rhc_pkg::result_type         result
);

   logic [5:0]                         header_length;
   logic [ipv4rhc_pkg::CountWidth-1:0] header_wide;
   logic [15:0]                        payload_length;
   logic                               addressed;
   ipv4rhc_pkg::verdict_type           verdict;
   ipv4rhc_pkg::protocol_class_type    protocol_class;

   always_comb begin
      header_length  = ipv4rhc_pkg::header_bytes(summary.version_ihl);
      header_wide    = {10'd0, header_length};
      payload_length = summary.total_length - header_wide;
      addressed = (summary.destination == local_address) ||
                  (summary.destination == ipv4rhc_pkg::LimitedBroadcast) ||
                  (summary.destination[31:28] == ipv4rhc_pkg::MulticastPrefix);

      if (summary.received_length < ipv4rhc_pkg::MinPacketBytes) begin
         verdict = ipv4rhc_pkg::VERDICT_SHORT;
      end else if (summary.version_ihl[7:4] != ipv4rhc_pkg::IpVersion4) begin
         verdict = ipv4rhc_pkg::VERDICT_VERSION;
      end else if (header_length < ipv4rhc_pkg::MinHeaderBytes ||
                   header_wide > summary.received_length) begin
         verdict = ipv4rhc_pkg::VERDICT_HEADER_LENGTH;
      end else if (summary.header_sum != ipv4rhc_pkg::ChecksumGood) begin
         verdict = ipv4rhc_pkg::VERDICT_CHECKSUM;
      end else if (!addressed) begin
         verdict = ipv4rhc_pkg::VERDICT_NOT_OURS;
      end else if (summary.total_length < header_wide ||
                   summary.total_length > summary.received_length) begin
         verdict = ipv4rhc_pkg::VERDICT_TOTAL_LENGTH;
      end else begin
         verdict = ipv4rhc_pkg::VERDICT_ACCEPT;
      end

      case (summary.protocol)
         ipv4rhc_pkg::ProtocolIcmp: protocol_class = ipv4rhc_pkg::CLASS_ICMP;
         ipv4rhc_pkg::ProtocolTcp:  protocol_class = ipv4rhc_pkg::CLASS_TCP;
         ipv4rhc_pkg::ProtocolUdp:  protocol_class = ipv4rhc_pkg::CLASS_UDP;
         default:                   protocol_class = ipv4rhc_pkg::CLASS_OTHER;
      endcase

      result = '0;
      result.verdict = verdict;
      if (verdict == ipv4rhc_pkg::VERDICT_ACCEPT) begin
         result.protocol_class = protocol_class;
         result.source_address = summary.source;
         result.header_length  = header_length;
         result.payload_length = payload_length;
         result.echo_request   = (protocol_class == ipv4rhc_pkg::CLASS_ICMP) &&
                                 (payload_length >= ipv4rhc_pkg::IcmpHeaderBytes) &&
                                 (summary.icmp_type_code == ipv4rhc_pkg::EchoTypeCode);
      end
   end

endmodule

[tb/sv/ipv4rhc_checker.sv]
module ipv4rhc_checker
   import ipv4rhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   ipv4rhc_req_if      req_beat,
   ipv4rhc_rsp_if      rsp_beat,
   output int unsigned failures,
   output int unsigned pending,
   output int unsigned verdicts_checked,
   output int unsigned accepted_count,
   output int unsigned echo_count
);

   logic [31:0] local_addr;
   logic [15:0] rx_count;
   logic [16:0] hdr_sum;
   logic [7:0]  held_byte;
   logic [7:0]  ver_ihl;
   logic [15:0] total_len;
   logic [7:0]  proto;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] type_code;

   result_type pending_verdicts[$];

   task automatic clear_packet_state();
      rx_count = '0;
      hdr_sum = '0;
      held_byte = '0;
      ver_ihl = '0;
      total_len = '0;
      proto = '0;
      src_addr = '0;
      dst_addr = '0;
      type_code = '0;
   endtask

   task automatic take_packet_byte(input logic [7:0] value, input logic last);
      logic [15:0] pos;
      logic        indexed;
      int unsigned hl;
      int unsigned folded;
      int unsigned rx;
      result_type  want;
      pos = rx_count;
      indexed = (pos != CountSaturate);
      if (indexed && pos == 0) begin
         ver_ihl = value;
      end
      hl = ver_ihl[3:0] * 4;
      if (indexed) begin
         if (pos < hl) begin
            if (!pos[0]) begin
               held_byte = value;
            end else begin
               folded = hdr_sum + {held_byte, value};
               folded = (folded & 32'hFFFF) + (folded >> 16);
               hdr_sum = folded[16:0];
            end
         end
         if (pos == LengthHighIndex) total_len[15:8] = value;
         if (pos == LengthLowIndex) total_len[7:0] = value;
         if (pos == ProtocolIndex) proto = value;
         if (pos >= SourceIndex && pos < DestinationIndex) begin
            src_addr = {src_addr[23:0], value};
         end
         if (pos >= DestinationIndex && pos < FixedHeaderEnd) begin
            dst_addr = {dst_addr[23:0], value};
         end
         if (pos == hl) type_code[15:8] = value;
         if (pos == hl + 1) type_code[7:0] = value;
         rx_count = pos + 16'd1;
      end
      if (last) begin
         rx = rx_count;
         want = '0;
         if (rx < MinPacketBytes) begin
            want.verdict = VERDICT_SHORT;
         end else if (ver_ihl[7:4] != IpVersion4) begin
            want.verdict = VERDICT_VERSION;
         end else if (hl < MinHeaderBytes || hl > rx) begin
            want.verdict = VERDICT_HEADER_LENGTH;
         end else if (hdr_sum != ChecksumGood) begin
            want.verdict = VERDICT_CHECKSUM;
         end else if (dst_addr != local_addr && dst_addr != LimitedBroadcast
                      && dst_addr[31:28] != MulticastPrefix) begin
            want.verdict = VERDICT_NOT_OURS;
         end else if (total_len < hl || total_len > rx) begin
            want.verdict = VERDICT_TOTAL_LENGTH;
         end else begin
            want.verdict = VERDICT_ACCEPT;
            case (proto)
               ProtocolIcmp: want.protocol_class = CLASS_ICMP;
               ProtocolTcp: want.protocol_class = CLASS_TCP;
               ProtocolUdp: want.protocol_class = CLASS_UDP;
               default: want.protocol_class = CLASS_OTHER;
            endcase
            want.source_address = src_addr;
            want.header_length = 6'(hl);
            want.payload_length = total_len - 16'(hl);
            want.echo_request = (want.protocol_class == CLASS_ICMP)
                                && (want.payload_length >= IcmpHeaderBytes)
                                && (type_code == EchoTypeCode);
         end
         pending_verdicts.push_back(want);
         clear_packet_state();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   task automatic check_verdict_beat();
      result_type want;
      if (pending_verdicts.size() == 0) begin
         $error("verdict beat with no packet outstanding: verdict %0d", rsp_beat.verdict);
         failures++;
      end else begin
         want = pending_verdicts.pop_front();
         check_field("verdict", want.verdict, rsp_beat.verdict);
         check_field("protocol_class", want.protocol_class, rsp_beat.protocol_class);
         check_field("source_address", want.source_address, rsp_beat.source_address);
         check_field("header_length", want.header_length, rsp_beat.header_length);
         check_field("payload_length", want.payload_length, rsp_beat.payload_length);
         check_field("echo_request", want.echo_request, rsp_beat.echo_request);
         verdicts_checked++;
         if (want.verdict == VERDICT_ACCEPT) accepted_count++;
         if (want.echo_request) echo_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_packet_state();
         local_addr = LocalAddressReset;
         pending_verdicts.delete();
         failures = 0;
         verdicts_checked = 0;
         accepted_count = 0;
         echo_count = 0;
      end else begin
         if (rsp_beat.valid && rsp_beat.ready) begin
            check_verdict_beat();
         end
         if (req_beat.valid && req_beat.ready) begin
            take_packet_byte(req_beat.data_byte, req_beat.last_byte);
         end
         if (csr_write_enable) begin
            local_addr = csr_write_data;
         end
      end
      pending = pending_verdicts.size();
   end

endmodule

[tb/sv/tb_ipv4_receive_header_check.sv]
module tb_ipv4_receive_header_check;
   import ipv4rhc_pkg::*;

   localparam int unsigned QuietLimit = 1000;

   typedef enum {
      FLAW_NONE,
      FLAW_FOREIGN,
      FLAW_VERSION,
      FLAW_IHL_LOW,
      FLAW_IHL_HIGH,
      FLAW_TOTAL,
      FLAW_CHECKSUM,
      FLAW_SHORT,
      FLAW_NOISE
   } flaw_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   ipv4rhc_req_if req_beat ();
   ipv4rhc_rsp_if rsp_beat ();

   int unsigned failures;
   int unsigned pending;
   int unsigned verdicts_checked;
   int unsigned accepted_count;
   int unsigned echo_count;

   logic [7:0]  pkt[$];
   logic [31:0] local_address_setting;
   int unsigned packets_sent;
   int unsigned bytes_sent;
   int unsigned address_writes;
   int unsigned quiet_cycles = 0;

   ipv4_receive_header_check u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_beat         (req_beat),
      .rsp_beat         (rsp_beat)
   );

   ipv4rhc_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_beat         (req_beat),
      .rsp_beat         (rsp_beat),
      .failures         (failures),
      .pending          (pending),
      .verdicts_checked (verdicts_checked),
      .accepted_count   (accepted_count),
      .echo_count       (echo_count)
   );

   initial clock = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned gap_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 10);
      else return $urandom_range(11, 40);
   endfunction

   function automatic flaw_type pick_flaw();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return FLAW_NONE;
      else if (roll < 63) return FLAW_FOREIGN;
      else if (roll < 70) return FLAW_VERSION;
      else if (roll < 75) return FLAW_IHL_LOW;
      else if (roll < 80) return FLAW_IHL_HIGH;
      else if (roll < 87) return FLAW_TOTAL;
      else if (roll < 93) return FLAW_CHECKSUM;
      else if (roll < 97) return FLAW_SHORT;
      else return FLAW_NOISE;
   endfunction

   function automatic logic [7:0] pick_protocol();
      case ($urandom_range(0, 3))
         0: return ProtocolIcmp;
         1: return ProtocolTcp;
         2: return ProtocolUdp;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_destination();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return local_address_setting;
      else if (roll < 55) return LimitedBroadcast;
      else if (roll < 75) return {MulticastPrefix, 28'($urandom)};
      else return $urandom;
   endfunction

   // The header checksum is filled in so that the folded header sum comes out
   // all ones; headers shorter than the checksum field are left as they are.
   task automatic build_packet(input logic [3:0] version, input logic [3:0] ihl,
                               input logic [7:0] protocol, input logic [31:0] destination,
                               input int payload_bytes, input int total_adjust,
                               input logic [15:0] type_code);
      int          hl;
      int          fixed_end;
      int          total;
      int          i;
      int unsigned word_sum;
      hl = ihl * 4;
      fixed_end = (hl < 20) ? 20 : hl;
      pkt.delete();
      for (i = 0; i < fixed_end + payload_bytes; i++) begin
         pkt.push_back(8'($urandom));
      end
      pkt[0] = {version, ihl};
      total = fixed_end + payload_bytes + total_adjust;
      if (total < 0) total = 0;
      if (total > 65535) total = 65535;
      pkt[2] = total[15:8];
      pkt[3] = total[7:0];
      pkt[9] = protocol;
      for (i = 0; i < 4; i++) begin
         pkt[16 + i] = destination[31 - 8 * i -: 8];
      end
      if (payload_bytes >= 2) begin
         pkt[fixed_end] = type_code[15:8];
         pkt[fixed_end + 1] = type_code[7:0];
      end
      if (hl >= 12) begin
         pkt[10] = 8'h00;
         pkt[11] = 8'h00;
         word_sum = 0;
         for (i = 0; i < hl; i += 2) begin
            word_sum += {pkt[i], pkt[i + 1]};
         end
         while (word_sum > 32'hFFFF) word_sum = (word_sum & 32'hFFFF) + (word_sum >> 16);
         pkt[10] = ~word_sum[15:8];
         pkt[11] = ~word_sum[7:0];
      end
   endtask

   task automatic trim_packet(input int length);
      while (pkt.size() > length) void'(pkt.pop_back());
   endtask

   task automatic fill_packet(input logic [7:0] value, input int length);
      pkt.delete();
      repeat (length) pkt.push_back(value);
   endtask

   task automatic send_byte(input logic [7:0] value, input logic last, input bit paced);
      int unsigned gap;
      gap = paced ? gap_len() : 0;
      if (gap != 0) begin
         req_beat.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_beat.valid = 1'b1;
      req_beat.data_byte = value;
      req_beat.last_byte = last;
      @(posedge clock);
      while (!req_beat.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_packet(input bit allow_gaps);
      bit paced;
      int i;
      paced = allow_gaps && ($urandom_range(0, 4) != 0);
      for (i = 0; i < pkt.size(); i++) begin
         send_byte(pkt[i], i == pkt.size() - 1, paced);
      end
      packets_sent++;
      bytes_sent += pkt.size();
   endtask

   task automatic set_local_address(input logic [31:0] value);
      req_beat.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      local_address_setting = value;
      address_writes++;
   endtask

   task automatic make_random_packet();
      flaw_type    flaw;
      logic [3:0]  version;
      logic [3:0]  ihl;
      logic [7:0]  protocol;
      logic [31:0] destination;
      logic [15:0] type_code;
      int          payload_bytes;
      int          adjust;
      int          cut;
      int          spot;
      flaw = pick_flaw();
      version = IpVersion4;
      ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
      protocol = pick_protocol();
      destination = pick_destination();
      type_code = ($urandom_range(0, 1) == 0) ? EchoTypeCode : 16'($urandom);
      payload_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                                   : $urandom_range(0, 16);
      adjust = ($urandom_range(0, 3) == 0) ? 0 - int'($urandom_range(0, payload_bytes)) : 0;
      cut = 1 << 20;
      case (flaw)
         FLAW_FOREIGN: destination = $urandom;
         FLAW_VERSION: begin
            version = 4'($urandom_range(0, 14));
            if (version == IpVersion4) version = 4'd15;
         end
         FLAW_IHL_LOW: ihl = 4'($urandom_range(0, 4));
         FLAW_IHL_HIGH: begin
            ihl = 4'($urandom_range(6, 15));
            payload_bytes = 0;
            adjust = 0;
         end
         FLAW_TOTAL: begin
            if ($urandom_range(0, 1) == 0) begin
               adjust = $urandom_range(1, 300);
            end else begin
               adjust = 0 - payload_bytes - int'($urandom_range(1, ihl * 4));
            end
         end
         default: ;
      endcase
      build_packet(version, ihl, protocol, destination, payload_bytes, adjust, type_code);
      case (flaw)
         FLAW_IHL_HIGH: cut = $urandom_range(20, ihl * 4 - 1);
         FLAW_SHORT: cut = $urandom_range(1, 19);
         FLAW_CHECKSUM: begin
            spot = $urandom_range(0, ihl * 4 - 1);
            pkt[spot] = pkt[spot] ^ 8'($urandom_range(1, 255));
         end
         FLAW_NOISE: begin
            pkt.delete();
            repeat ($urandom_range(1, 64)) pkt.push_back(8'($urandom));
         end
         default: ;
      endcase
      trim_packet(cut);
   endtask

   initial begin
      int unsigned stall_left;
      bit          steady;
      stall_left = 0;
      steady = 1'b0;
      rsp_beat.ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 299) == 0) steady = !steady;
         if (stall_left != 0) begin
            rsp_beat.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_beat.ready = 1'b1;
            if (!steady && $urandom_range(0, 2) == 0) stall_left = gap_len();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_beat.valid && req_beat.ready) || (rsp_beat.valid && rsp_beat.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QuietLimit);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int          phase;
      logic [31:0] address;
      int unsigned phase_bytes;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_beat.valid = 1'b0;
      req_beat.data_byte = '0;
      req_beat.last_byte = 1'b0;
      local_address_setting = LocalAddressReset;
      packets_sent = 0;
      bytes_sent = 0;
      address_writes = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Out of reset the local address is zero, so a zero destination is ours.
      build_packet(IpVersion4, 4'd5, ProtocolUdp, 32'h0, 4, 0, 16'h0);
      send_packet(1'b1);
      set_local_address(32'hC0A8_0A05);

      build_packet(IpVersion4, 4'd5, ProtocolUdp, local_address_setting, 0, 0, 16'h0);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd6, ProtocolTcp, LimitedBroadcast, 10, 0, 16'h0);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, ProtocolIcmp, 32'hE000_0001, 8, 0, EchoTypeCode);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, ProtocolIcmp, local_address_setting, 7, 0, EchoTypeCode);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, ProtocolIcmp, local_address_setting, 12, 0, 16'h0801);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, ProtocolIcmp, local_address_setting, 16, -4, EchoTypeCode);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, 8'h59, 32'hEFFF_FFFF, 4, 0, 16'h0);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd15, ProtocolTcp, local_address_setting, 4, -4, 16'h0);
      send_packet(1'b1);

      build_packet(IpVersion4, 4'd5, ProtocolUdp, local_address_setting, 0, 0, 16'h0);
      trim_packet(1);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, ProtocolUdp, local_address_setting, 0, 0, 16'h0);
      trim_packet(19);
      send_packet(1'b1);
      build_packet(4'd6, 4'd5, ProtocolUdp, local_address_setting, 4, 0, 16'h0);
      send_packet(1'b1);
      build_packet(4'd15, 4'd5, ProtocolUdp, local_address_setting, 4, 0, 16'h0);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd4, ProtocolUdp, local_address_setting, 4, 0, 16'h0);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd0, ProtocolUdp, local_address_setting, 4, 0, 16'h0);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd15, ProtocolUdp, local_address_setting, 0, 0, 16'h0);
      trim_packet(40);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, ProtocolUdp, local_address_setting, 6, 0, 16'h0);
      pkt[10] = pkt[10] ^ 8'h01;
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, ProtocolUdp, 32'h0A00_0001, 6, 0, 16'h0);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, ProtocolUdp, 32'hDFFF_FFFF, 6, 0, 16'h0);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, ProtocolUdp, 32'hF000_0000, 6, 0, 16'h0);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, ProtocolUdp, local_address_setting, 4, 1, 16'h0);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, ProtocolUdp, local_address_setting, 4, -5, 16'h0);
      send_packet(1'b1);
      build_packet(IpVersion4, 4'd5, ProtocolUdp, local_address_setting, 4, 65535, 16'h0);
      send_packet(1'b1);
      fill_packet(8'hFF, 20);
      send_packet(1'b1);
      fill_packet(8'h00, 24);
      send_packet(1'b1);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: address = $urandom;
            1: address = LimitedBroadcast;
            2: address = 32'h0;
            default: address = {MulticastPrefix, 28'($urandom)};
         endcase
         set_local_address(address);
         phase_bytes = bytes_sent;
         while (bytes_sent - phase_bytes < 40) begin
            make_random_packet();
            send_packet(1'b1);
         end
      end

      req_beat.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Sent %0d packets (%0d bytes) under %0d local address settings.",
               packets_sent, bytes_sent, address_writes);
      $display("Checked %0d verdicts: %0d accepted, %0d echo requests, %0d failures.",
               verdicts_checked, accepted_count, echo_count, failures);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/ipv4rhc_pkg.sv
hdl/ipv4rhc_if.sv
hdl/ipv4rhc_capture.sv
hdl/ipv4rhc_judge.sv
hdl/ipv4_receive_header_check.sv
tb/sv/ipv4rhc_checker.sv
tb/sv/tb_ipv4_receive_header_check.sv
